@@ rtl/sdt_pkg.sv @@
// Shared constants and types for the tag sort and deduplicate block.
package sdt_pkg;

    localparam int MAX_TAGS = 64;
    localparam int TAG_W    = 32;
    localparam int CNT_W    = $clog2(MAX_TAGS + 1);
    localparam int IDX_W    = $clog2(MAX_TAGS);

    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [CNT_W-1:0] t_cnt;

    // Tag moving down the chain; probe marks a lookup in a full store.
    typedef struct packed {
        logic v;
        logic probe;
        t_tag tag;
    } t_carry;

    // Per-cell control from the top level.
    typedef struct packed {
        logic occ;
        logic shift;
    } t_cell_ctl;

endpackage

@@ rtl/sdt_in_if.sv @@
// Request channel carrying one tag and its end-of-set flag.
interface sdt_in_if;
    logic          valid;
    logic          ready;
    logic [31:0]   tag_value;
    logic          set_end;

    modport source (output valid, output tag_value, output set_end, input ready);
    modport sink   (input valid, input tag_value, input set_end, output ready);
endinterface

@@ rtl/sdt_out_if.sv @@
// Result channel carrying one sorted distinct tag and its flags.
interface sdt_out_if;
    logic          valid;
    logic          ready;
    logic [31:0]   sorted_tag;
    logic          final_tag;
    logic          capacity_exceeded;

    modport source (output valid, output sorted_tag, output final_tag,
                    output capacity_exceeded, input ready);
    modport sink   (input valid, input sorted_tag, input final_tag,
                    input capacity_exceeded, output ready);
endinterface

@@ rtl/sdt_cell.sv @@
// One cell of the insertion chain: holds one tag, passes displaced tags on.
module sdt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdt_pkg::t_cell_ctl i_ctl,
    input  sdt_pkg::t_tag     i_next_tag,
    input  sdt_pkg::t_carry   i_carry,
    output sdt_pkg::t_tag     o_tag,
    output sdt_pkg::t_carry   o_carry
);
    import sdt_pkg::*;

    t_tag   r_tag;
    t_tag   n_tag;
    t_carry r_carry;
    t_carry n_carry;

    always_comb begin
        n_tag   = r_tag;
        n_carry = '0;
        if (i_ctl.shift) begin
            n_tag = i_next_tag;
        end else if (i_carry.v) begin
            if (!i_ctl.occ) begin
                // absorb into the first free cell
                if (!i_carry.probe) begin
                    n_tag = i_carry.tag;
                end
            end else if (i_carry.tag == r_tag) begin
                n_carry = '0;   // duplicate: drop
            end else if ((i_carry.tag < r_tag) && !i_carry.probe) begin
                n_tag   = i_carry.tag;
                n_carry = '{v: 1'b1, probe: 1'b0, tag: r_tag};
            end else begin
                n_carry = i_carry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        if (!i_rst_n) begin
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
        end
    end

    assign o_tag   = r_tag;
    assign o_carry = r_carry;

endmodule

@@ rtl/sort_dedup_tags.sv @@
// Top level: systolic insertion sorter that drops duplicate tags per set.
// An accepted tag enters cell 0 and moves down the chain until it settles (cell n
//   is the last one it can reach while n tags are held); a full store probes every cell.
// Each item settles before the next is taken; after the set end, one result per cycle while ready.
// Results leave from cell 0 while the chain shifts toward it, which also empties it.
// Reset (synchronous, active low) clears the count, overflow flag, control and
//   in-flight carries; stored tag contents are left as they are.
module sort_dedup_tags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdt_in_if.sink      i_in,
    sdt_out_if.source   o_out
);
    import sdt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT
    } t_state;

    t_state    r_state,  n_state;
    t_cnt      r_cnt,    n_cnt;
    t_cnt      r_step,   n_step;
    logic      r_ovf,    n_ovf;
    logic      r_last,   n_last;
    logic      r_ovalid, n_ovalid;
    t_tag      r_otag,   n_otag;
    logic      r_ofinal, n_ofinal;
    logic      r_oovf,   n_oovf;

    logic      in_acc;
    logic      shift;
    logic      event_v;
    logic      finish;
    logic      load;
    t_cnt      step_m1;

    t_tag      cell_tag   [MAX_TAGS];
    t_carry    cell_carry [MAX_TAGS];
    t_carry    head_carry;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // Incoming request enters cell 0 in the cycle it is accepted.
    assign head_carry = '{v: in_acc, probe: (r_cnt == t_cnt'(MAX_TAGS)), tag: i_in.tag_value};

    // Carry arriving at the cell processed this cycle; cell 0 takes the request.
    assign step_m1 = r_step - t_cnt'(1);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_step   = r_step;
        n_ovf    = r_ovf;
        n_last   = r_last;
        n_ovalid = r_ovalid;
        n_otag   = r_otag;
        n_ofinal = r_ofinal;
        n_oovf   = r_oovf;
        shift    = 1'b0;
        finish   = 1'b0;
        event_v  = 1'b0;
        load     = 1'b0;

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_last  = i_in.set_end;
                    event_v = 1'b1;
                    if (r_cnt == '0) begin
                        finish = 1'b1;
                    end else begin
                        n_state = ST_INSERT;
                        n_step  = t_cnt'(1);
                    end
                end
            end
            ST_INSERT: begin
                event_v = cell_carry[step_m1[IDX_W-1:0]].v;
                if (r_step == r_cnt) begin
                    finish = 1'b1;
                end else begin
                    n_step = r_step + t_cnt'(1);
                end
            end
            ST_EMIT: begin
                // hold the result until the sink takes it, then advance the chain
                load = !r_ovalid || o_out.ready;
                if (load) begin
                    shift    = 1'b1;
                    n_ovalid = 1'b1;
                    n_otag   = cell_tag[0];
                    n_ofinal = (r_cnt == t_cnt'(1));
                    n_oovf   = r_ovf;
                    n_cnt    = r_cnt - t_cnt'(1);
                    if (r_cnt == t_cnt'(1)) begin
                        n_ovf   = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Settle the request: a carry reaching cell r_cnt is a new distinct tag.
        if (finish) begin
            if (event_v) begin
                if (r_cnt == t_cnt'(MAX_TAGS)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_cnt = r_cnt + t_cnt'(1);
                end
            end
            n_state = (r_state == ST_IDLE ? i_in.set_end : r_last) ? ST_EMIT : ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_last   <= n_last;
        r_otag   <= n_otag;
        r_ofinal <= n_ofinal;
        r_oovf   <= n_oovf;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    // The chain of cells; occupancy follows from the count.
    for (genvar g = 0; g < MAX_TAGS; g++) begin : g_cell
        t_cell_ctl ctl;
        assign ctl.occ   = (t_cnt'(g) < r_cnt);
        assign ctl.shift = shift;

        sdt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_next_tag (cell_tag[(g == MAX_TAGS - 1) ? g : g + 1]),
            .i_carry    ((g == 0) ? head_carry : cell_carry[(g == 0) ? 0 : g - 1]),
            .o_tag      (cell_tag[g]),
            .o_carry    (cell_carry[g])
        );
    end

    assign o_out.valid             = r_ovalid;
    assign o_out.sorted_tag        = r_otag;
    assign o_out.final_tag         = r_ofinal;
    assign o_out.capacity_exceeded = r_oovf;

endmodule

@@ rtl/sdt_checker.sv @@
// Port-level assertions for the tag sorter, bound to the top level.
module sdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_tag,
    input logic        i_out_final,
    input logic        i_out_ovf
);
    logic out_acc;
    assign out_acc = i_out_valid && i_out_ready;

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_tag)
            && $stable(i_out_final) && $stable(i_out_ovf)))
        else $error("stalled result changed");

    // no new request while a set is still being emitted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_final) |-> !i_in_ready)
        else $error("request taken during emission");

    // results of one set follow each other in strictly ascending order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !i_out_final) |=> (i_out_valid && (i_out_tag > $past(i_out_tag))))
        else $error("results not strictly ascending");

    // overflow flag is the same on every result of a set
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !i_out_final) |=> (i_out_ovf == $past(i_out_ovf)))
        else $error("overflow flag changed within a set");

endmodule

bind sort_dedup_tags sdt_checker u_sdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_tag   (o_out.sorted_tag),
    .i_out_final (o_out.final_tag),
    .i_out_ovf   (o_out.capacity_exceeded)
);
